/* design/kochsg_pkg.sv */
`timescale 1ns / 1ps

package kochsg_pkg;

  localparam int MAX_DEPTH_DEF = 6;
  localparam int FRAC_BITS_DEF = 8;

  localparam int IN_W  = 24;
  localparam int PIX_W = 16;
  localparam int CW    = 28;
  localparam int DW    = CW + 1;
  localparam int NW    = 48;
  localparam int MUL_W = 33;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EMIT = 1'b1;

  localparam logic [31:0] DIV3_RECIP = 32'hAAAA_AAAB;
  localparam logic [31:0] DIV_Q_BIAS = 32'(64'd1 << (DW - 1));
  localparam logic [31:0] DIV_N_BIAS = 32'(64'd3 << (DW - 1));
  localparam logic [16:0] SQRT3_HALF = 17'd56756;

  localparam logic signed [CW-1:0] PIX_MAX = CW'(32767);
  localparam logic signed [CW-1:0] PIX_MIN = -CW'(32768);

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;

  function automatic logic signed [PIX_W-1:0] sat_pix(input logic signed [CW-1:0] v);
    logic signed [PIX_W-1:0] r;
    if (v > PIX_MAX) begin
      r = 16'sh7FFF;
    end else if (v < PIX_MIN) begin
      r = 16'sh8000;
    end else begin
      r = PIX_W'(v);
    end
    return r;
  endfunction

endpackage

/* design/koch_curve_segment_generator_unit.sv */
`timescale 1ns / 1ps
// Load transfer: accepted while idle, no result.
// Emit transfer: per level, states TX, TY, SRX, SRY, UPD; then OUT registers the result; one shared
// 33x33 multiplier does four products per level (two divide-by-3, two rotations).
// in_stall is high during the walk and in OUT, so the next transfer waits for the result.
// Reset (rst, synchronous): depth 0, nothing loaded, output empty.
module koch_curve_segment_generator_unit #(
  parameter int MAX_DEPTH = kochsg_pkg::MAX_DEPTH_DEF,
  parameter int FRAC_BITS = kochsg_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [2:0]                             cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   command,
  input  logic signed [kochsg_pkg::IN_W-1:0]     x_start,
  input  logic signed [kochsg_pkg::IN_W-1:0]     y_start,
  input  logic signed [kochsg_pkg::IN_W-1:0]     x_end,
  input  logic signed [kochsg_pkg::IN_W-1:0]     y_end,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [kochsg_pkg::PIX_W-1:0]    line_x0,
  output logic signed [kochsg_pkg::PIX_W-1:0]    line_y0,
  output logic signed [kochsg_pkg::PIX_W-1:0]    line_x1,
  output logic signed [kochsg_pkg::PIX_W-1:0]    line_y1,
  output logic                                   last_line
);

  localparam int LW = $clog2(MAX_DEPTH + 1);
  localparam int IW = 2 * MAX_DEPTH;
  localparam int CW = kochsg_pkg::CW;
  localparam int DW = kochsg_pkg::DW;
  localparam int NW = kochsg_pkg::NW;
  localparam int MW = kochsg_pkg::MUL_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_TX   = 3'd1;
  localparam logic [2:0] ST_TY   = 3'd2;
  localparam logic [2:0] ST_SRX  = 3'd3;
  localparam logic [2:0] ST_SRY  = 3'd4;
  localparam logic [2:0] ST_UPD  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  localparam logic [0:0] CMD_LOAD = kochsg_pkg::CMD_LOAD;

  logic [2:0]                state;
  logic [2:0]                depth;
  logic [LW-1:0]             run_depth;
  logic [LW-1:0]             lvl;
  logic [IW-1:0]             index;
  logic                      active;
  kochsg_pkg::coord_t        sx0, sy0, sx1, sy1;
  kochsg_pkg::coord_t        ax, ay, bx, by;
  kochsg_pkg::diff_t         tx, ty, rx, ry;
  logic signed [NW-1:0]      srx;
  logic signed [2*MW-1:0]    p;

  logic signed [MW-1:0]      mul_a, mul_b;
  logic signed [2*MW-1:0]    mul_p;
  kochsg_pkg::diff_t         dx, dy, rx_c, ry_c, q_t;
  logic [31:0]               q;
  logic signed [NW-1:0]      sry, rx_w, ry_w, ex_num, ey_num;
  kochsg_pkg::coord_t        cx, cy, dpx, dpy, ex, ey;
  logic [LW:0]               shamt;
  logic [1:0]                digit;
  logic [IW-1:0]             mask;
  logic                      last;
  kochsg_pkg::coord_t        pax, pay, pbx, pby;
  logic                      accept, take;

  function automatic kochsg_pkg::coord_t to_pix(input kochsg_pkg::coord_t v);
    kochsg_pkg::coord_t s;
    s = v >>> FRAC_BITS;
    if (v[CW-1] && (v[FRAC_BITS-1:0] != '0)) begin
      s = s + CW'(1);
    end
    return s;
  endfunction

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign take     = out_valid && !out_stall;

  assign dx   = DW'(bx) - DW'(ax);
  assign dy   = DW'(by) - DW'(ay);
  assign rx_c = dx - (tx <<< 1);
  assign ry_c = dy - (ty <<< 1);
  assign q    = p[64:33];
  assign q_t  = DW'(q - kochsg_pkg::DIV_Q_BIAS);
  assign mul_p = mul_a * mul_b;

  always_comb begin
    unique case (state)
      ST_TX: begin
        mul_a = {1'b0, 32'(dx) + kochsg_pkg::DIV_N_BIAS};
        mul_b = {1'b0, kochsg_pkg::DIV3_RECIP};
      end
      ST_TY: begin
        mul_a = {1'b0, 32'(dy) + kochsg_pkg::DIV_N_BIAS};
        mul_b = {1'b0, kochsg_pkg::DIV3_RECIP};
      end
      ST_SRX: begin
        mul_a = MW'(rx_c);
        mul_b = MW'($signed({1'b0, kochsg_pkg::SQRT3_HALF}));
      end
      ST_SRY: begin
        mul_a = MW'(ry_c);
        mul_b = MW'($signed({1'b0, kochsg_pkg::SQRT3_HALF}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // new points of the current level
  always_comb begin
    sry    = p[NW-1:0];
    rx_w   = NW'(rx);
    ry_w   = NW'(ry);
    cx     = CW'(DW'(ax) + tx);
    cy     = CW'(DW'(ay) + ty);
    dpx    = CW'(DW'(ax) + (tx <<< 1));
    dpy    = CW'(DW'(ay) + (ty <<< 1));
    ex_num = -(rx_w <<< 15) - sry;
    ey_num = srx - (ry_w <<< 15);
    ex     = dpx + CW'(ex_num >>> 16);
    ey     = dpy + CW'(ey_num >>> 16);
    shamt  = {lvl - LW'(1), 1'b0};
    digit  = 2'(index >> shamt);
  end

  always_comb begin
    for (int i = 0; i < MAX_DEPTH; i++) begin
      mask[2*i +: 2] = (i < int'(run_depth)) ? 2'b11 : 2'b00;
    end
    last = &(index | ~mask);
    pax  = to_pix(ax);
    pay  = to_pix(ay);
    pbx  = to_pix(bx);
    pby  = to_pix(by);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      depth     <= '0;
      run_depth <= '0;
      lvl       <= '0;
      index     <= '0;
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        depth <= cfg_wdata;
      end
      if (take && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (command == CMD_LOAD) begin
              run_depth <= (int'(depth) > MAX_DEPTH) ? LW'(MAX_DEPTH) : LW'(depth);
              index     <= '0;
              active    <= 1'b1;
            end else if (active) begin
              lvl   <= run_depth;
              state <= (run_depth == '0) ? ST_OUT : ST_TX;
            end
          end
        end
        ST_TX:  state <= ST_TY;
        ST_TY:  state <= ST_SRX;
        ST_SRX: state <= ST_SRY;
        ST_SRY: state <= ST_UPD;
        ST_UPD: begin
          lvl   <= lvl - LW'(1);
          state <= (lvl == LW'(1)) ? ST_OUT : ST_TX;
        end
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
            if (last) begin
              active <= 1'b0;
              index  <= '0;
            end else begin
              index <= index + IW'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    p <= mul_p;
    if (accept && (command == CMD_LOAD)) begin
      sx0 <= CW'(x_start);
      sy0 <= CW'(y_start);
      sx1 <= CW'(x_end);
      sy1 <= CW'(y_end);
    end
    unique case (state)
      ST_IDLE: begin
        ax <= sx0;
        ay <= sy0;
        bx <= sx1;
        by <= sy1;
      end
      ST_TY:  tx <= q_t;
      ST_SRX: begin
        ty <= q_t;
        rx <= rx_c;
      end
      ST_SRY: begin
        srx <= p[NW-1:0];
        ry  <= ry_c;
      end
      ST_UPD: begin
        unique case (digit)
          2'd0: begin
            bx <= cx;
            by <= cy;
          end
          2'd1: begin
            ax <= cx;
            ay <= cy;
            bx <= ex;
            by <= ey;
          end
          2'd2: begin
            ax <= ex;
            ay <= ey;
            bx <= dpx;
            by <= dpy;
          end
          default: begin
            ax <= dpx;
            ay <= dpy;
          end
        endcase
      end
      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          line_x0   <= kochsg_pkg::sat_pix(pax);
          line_y0   <= kochsg_pkg::sat_pix(pay);
          line_x1   <= kochsg_pkg::sat_pix(pbx);
          line_y1   <= kochsg_pkg::sat_pix(pby);
          last_line <= last;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* tb/koch_curve_segment_generator_unit_test.sv */
`timescale 1ns / 1ps

module koch_curve_segment_generator_unit_test;

  localparam logic CMD_LOAD = kochsg_pkg::CMD_LOAD;
  localparam logic CMD_EMIT = kochsg_pkg::CMD_EMIT;

  localparam int PIECE_AC = 0;
  localparam int PIECE_CE = 1;
  localparam int PIECE_ED = 2;
  localparam int PIECE_DB = 3;

  localparam int     MAX_LEVELS    = kochsg_pkg::MAX_DEPTH_DEF;
  localparam longint ROT_HALF      = 32768;  // 1/2 in Q16
  localparam longint ROT_SIN       = 56756;  // sqrt(3)/2 in Q16
  localparam int     SETTLE_CYCLES = 5 * MAX_LEVELS + 10;
  localparam int     HOLD_CYCLES   = 300;
  localparam int     END_WAIT      = 2000;
  localparam int     QUIET_LIMIT   = 4000;
  localparam int     RANDOM_ITEMS  = 1050;

  typedef logic signed [kochsg_pkg::IN_W-1:0]  fix_t;
  typedef logic signed [kochsg_pkg::PIX_W-1:0] pix_t;

  typedef struct {
    pix_t x0;
    pix_t y0;
    pix_t x1;
    pix_t y1;
    logic last;
  } line_t;

  localparam fix_t FIX_MAX = 24'sh7FFFFF;
  localparam fix_t FIX_MIN = 24'sh800000;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [2:0] cfg_wdata;
  logic       in_valid;
  logic       in_stall;
  logic       command;
  fix_t       x_start, y_start, x_end, y_end;
  logic       out_valid;
  logic       out_stall;
  pix_t       line_x0, line_y0, line_x1, line_y1;
  logic       last_line;

  koch_curve_segment_generator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .x_start   (x_start),
    .y_start   (y_start),
    .x_end     (x_end),
    .y_end     (y_end),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .line_x0   (line_x0),
    .line_y0   (line_y0),
    .line_x1   (line_x1),
    .line_y1   (line_y1),
    .last_line (last_line)
  );

  always #1 clk = ~clk;

  // Generator model state
  logic [2:0]  depth_reg;
  longint      seg_ax, seg_ay, seg_bx, seg_by;
  logic [11:0] seg_index;
  logic        walk_active;
  int          walk_depth;
  line_t       expected_lines[$];

  int errors;
  int n_loads, n_lines, n_ignored, n_ends, n_checked;
  int hold_ticket;
  bit idle_on;

  function automatic longint floor_div(longint num, longint den);
    longint q;
    q = num / den;
    if (num % den != 0 && num < 0) q -= 1;
    return q;
  endfunction

  function automatic pix_t to_pixel(longint v);
    longint p;
    p = v / (longint'(1) << kochsg_pkg::FRAC_BITS_DEF);
    if (p > 32767) p = 32767;
    if (p < -32768) p = -32768;
    return pix_t'(p);
  endfunction

  function automatic fix_t rand_coord();
    int pick;
    pick = $urandom_range(3);
    if (pick < 2) return fix_t'($urandom);
    if (pick == 2) return fix_t'(int'($urandom_range(131071)) - 65536);
    return $urandom_range(1) ? FIX_MAX : FIX_MIN;
  endfunction

  // Applies one accepted transfer to the model; queues the sub-segment an emit yields.
  task automatic predict_transfer(logic cmd, fix_t xs, fix_t ys, fix_t xe, fix_t ye);
    longint ax, ay, bx, by, tx, ty, cx, cy, dx, dy, ex, ey, rx, ry;
    int     lvl, digit;
    line_t  ln;
    if (cmd == CMD_LOAD) begin
      seg_ax = xs;
      seg_ay = ys;
      seg_bx = xe;
      seg_by = ye;
      walk_depth = (depth_reg > MAX_LEVELS) ? MAX_LEVELS : int'(depth_reg);
      seg_index = '0;
      walk_active = 1'b1;
      n_loads++;
      return;
    end
    if (!walk_active) begin
      n_ignored++;
      return;
    end
    ax = seg_ax;
    ay = seg_ay;
    bx = seg_bx;
    by = seg_by;
    for (lvl = walk_depth; lvl > 0; lvl--) begin
      digit = int'((seg_index >> (2 * (lvl - 1))) & 12'd3);
      tx = floor_div(bx - ax, 3);
      ty = floor_div(by - ay, 3);
      cx = ax + tx;
      cy = ay + ty;
      dx = cx + tx;
      dy = cy + ty;
      rx = bx - dx;
      ry = by - dy;
      ex = dx + floor_div(-ROT_HALF * rx - ROT_SIN * ry, 65536);
      ey = dy + floor_div(ROT_SIN * rx - ROT_HALF * ry, 65536);
      case (digit)
        PIECE_AC: begin
          bx = cx;
          by = cy;
        end
        PIECE_CE: begin
          ax = cx;
          ay = cy;
          bx = ex;
          by = ey;
        end
        PIECE_ED: begin
          ax = ex;
          ay = ey;
          bx = dx;
          by = dy;
        end
        PIECE_DB: begin
          ax = dx;
          ay = dy;
        end
      endcase
    end
    ln.x0 = to_pixel(ax);
    ln.y0 = to_pixel(ay);
    ln.x1 = to_pixel(bx);
    ln.y1 = to_pixel(by);
    ln.last = (int'(seg_index) + 1) >= (1 << (2 * walk_depth));
    expected_lines.push_back(ln);
    n_lines++;
    if (ln.last) begin
      walk_active = 1'b0;
      seg_index = '0;
      n_ends++;
    end else begin
      seg_index++;
    end
  endtask

  task automatic send_item(logic cmd, fix_t xs, fix_t ys, fix_t xe, fix_t ye);
    int gap;
    gap = 0;
    if (idle_on) begin
      while ($urandom_range(99) < 26) gap++;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    x_start  <= xs;
    y_start  <= ys;
    x_end    <= xe;
    y_end    <= ye;
    do @(posedge clk); while (in_stall);
    predict_transfer(cmd, xs, ys, xe, ye);
  endtask

  task automatic emit_lines(int count);
    repeat (count) send_item(CMD_EMIT, rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic load_random();
    send_item(CMD_LOAD, rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  // Only written with the block drained and settled.
  task automatic write_depth(logic [2:0] value);
    in_valid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    depth_reg = value;
  endtask

  task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    line_t want;
    if (!rst && out_valid && !out_stall) begin
      n_checked++;
      if (expected_lines.size() == 0) begin
        errors++;
        $display("%0t: unexpected line (%0d,%0d)-(%0d,%0d) last %0b", $time,
                 line_x0, line_y0, line_x1, line_y1, last_line);
      end else begin
        want = expected_lines.pop_front();
        check_field("line_x0", want.x0, line_x0);
        check_field("line_y0", want.y0, line_y0);
        check_field("line_x1", want.x1, line_x1);
        check_field("line_y1", want.y1, line_y1);
        check_field("last_line", want.last, last_line);
      end
    end
  end

  // Output side: random stalls, plus a long hold-off on request.
  initial begin : output_stall
    int seen;
    seen = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ticket != seen) begin
        seen = hold_ticket;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= idle_on && ($urandom_range(99) < 26);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: timeout, no transfer for %0d cycles", $time, QUIET_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  task automatic test_emit_before_load();
    emit_lines(2);
  endtask

  task automatic test_depth_zero();
    send_item(CMD_LOAD, FIX_MIN, FIX_MAX, FIX_MAX, FIX_MIN);
    emit_lines(2);
    send_item(CMD_LOAD, 24'sd0, -24'sd257, -24'sd1, 24'sd5120);
    emit_lines(1);
  endtask

  task automatic test_depth_one();
    write_depth(3'd1);
    send_item(CMD_LOAD, 24'sd0, 24'sd0, 24'sd196608, 24'sd0);
    emit_lines(5);
  endtask

  // Depth 7 saturates to the maximum; a write mid-walk waits for the next load.
  task automatic test_depth_saturation();
    write_depth(3'd7);
    send_item(CMD_LOAD, FIX_MIN, FIX_MIN, FIX_MAX, FIX_MAX);
    emit_lines(3);
    write_depth(3'd2);
    emit_lines(2);
    load_random();
    emit_lines(2);
  endtask

  task automatic test_output_backpressure();
    write_depth(3'd1);
    load_random();
    hold_ticket++;
    emit_lines(4);
    load_random();
    emit_lines(4);
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    write_depth(3'd2);
    repeat (6) begin
      load_random();
      emit_lines(16);
    end
    idle_on = 1'b1;
  endtask

  task automatic test_random_walks();
    int d, r, segs, full, n, start;
    start = n_loads + n_lines + n_ignored;
    while (n_loads + n_lines + n_ignored - start < RANDOM_ITEMS) begin
      r = $urandom_range(99);
      d = (r < 15) ? 0 : (r < 40) ? 1 : (r < 65) ? 2 : (r < 82) ? 3 :
          (r < 90) ? 4 : (r < 94) ? 5 : (r < 97) ? 6 : 7;
      write_depth(3'(d));
      if ($urandom_range(3) == 0) emit_lines($urandom_range(1, 3));
      full = 1 << (2 * ((d > MAX_LEVELS) ? MAX_LEVELS : d));
      segs = $urandom_range(1, 4);
      repeat (segs) begin
        load_random();
        if (d <= 3 || (d == 4 && $urandom_range(4) == 0)) n = full;
        else n = $urandom_range(1, 20);
        if ($urandom_range(9) == 0) n = $urandom_range(0, n);
        else if (d <= 3) n += $urandom_range(0, 2);
        emit_lines(n);
      end
    end
  endtask

  initial begin : main
    int waited;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    command   <= CMD_LOAD;
    x_start   <= '0;
    y_start   <= '0;
    x_end     <= '0;
    y_end     <= '0;
    depth_reg = '0;
    seg_ax = 0;
    seg_ay = 0;
    seg_bx = 0;
    seg_by = 0;
    seg_index = '0;
    walk_active = 1'b0;
    walk_depth = 0;
    errors = 0;
    n_loads = 0;
    n_lines = 0;
    n_ignored = 0;
    n_ends = 0;
    n_checked = 0;
    hold_ticket = 0;
    idle_on = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_emit_before_load();
    test_depth_zero();
    test_depth_one();
    test_depth_saturation();
    test_output_backpressure();
    test_steady_stream();
    test_random_walks();

    in_valid <= 1'b0;
    waited = 0;
    while (expected_lines.size() != 0 && waited < END_WAIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_lines.size() != 0) begin
      errors++;
      $display("%0t: %0d expected lines never arrived", $time, expected_lines.size());
    end
    $display("Run covered %0d loads, %0d lines checked, %0d walk ends, %0d ignored emits,",
             n_loads, n_checked, n_ends, n_ignored);
    $display("depths 0 to 7, a mid-walk depth change and a long output hold-off; %0d errors",
             errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
